// ----- sv/ptm_pkg.sv -----
// Package with the request, result, command and status types of the page table mapper.
package ptm_pkg;

	localparam int unsigned IDX_W   = 9;
	localparam int unsigned OFS_W   = 12;
	localparam logic        REQ_ALLOC = 1'b0;
	localparam logic        REQ_MAP   = 1'b1;
	localparam logic        ST_OK     = 1'b0;
	localparam logic        ST_FAIL   = 1'b1;
	localparam logic [OFS_W-1:0] PTE_PW = 12'h003;

	typedef struct packed {
		logic        req_type;
		logic [47:0] vaddr;
		logic [63:0] paddr;
		logic [63:0] flags;
	} in_t;

	typedef struct packed {
		logic        status;
		logic [23:0] frame_addr;
	} out_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_RD,
		S_CHK,
		S_LEAF,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load_req;
		logic rd;
		logic take_entry;
		logic alloc_table;
		logic alloc_frame;
		logic write_leaf;
		logic set_result;
		logic res_status;
		logic res_frame;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic present;
		logic in_range;
		logic full;
		logic last_level;
		logic req_map;
		logic out_busy;
	} sts_t;

endpackage

// ----- sv/ptm_ctrl.sv -----
// Controller state machine of the page table mapper.
module ptm_ctrl import ptm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_fire,
	input  sts_t   sts,
	output cmd_t   cmd,
	output logic   idle
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:  if (in_fire) state_d = S_ALLOC;
			S_ALLOC: state_d = sts.req_map ? S_RD : S_DONE;
			S_RD:    state_d = S_CHK;
			S_CHK: begin
				if (sts.present ? !sts.in_range : sts.full) begin
					state_d = S_DONE;
				end else if (sts.last_level) begin
					state_d = S_LEAF;
				end else begin
					state_d = S_RD;
				end
			end
			S_LEAF:  state_d = S_DONE;
			S_DONE:  if (!sts.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		idle = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				idle         = 1'b1;
				cmd.load_req = in_fire;
			end
			S_ALLOC: begin
				if (!sts.req_map) begin
					cmd.set_result  = 1'b1;
					cmd.res_status  = sts.full;
					cmd.res_frame   = !sts.full;
					cmd.alloc_frame = !sts.full;
				end
			end
			S_RD: cmd.rd = 1'b1;
			S_CHK: begin
				if (sts.present) begin
					if (sts.in_range) begin
						cmd.take_entry = 1'b1;
					end else begin
						cmd.set_result = 1'b1;
						cmd.res_status = ST_FAIL;
					end
				end else if (sts.full) begin
					cmd.set_result = 1'b1;
					cmd.res_status = ST_FAIL;
				end else begin
					cmd.alloc_table = 1'b1;
				end
			end
			S_LEAF: begin
				cmd.write_leaf = 1'b1;
				cmd.set_result = 1'b1;
				cmd.res_status = ST_OK;
			end
			S_DONE: cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

// ----- sv/ptm_dp.sv -----
// Datapath of the page table mapper: table memory, frame counter, walk and result registers.
module ptm_dp import ptm_pkg::*; #(
	parameter int unsigned RESERVED_FRAMES = 2048,
	parameter int unsigned ALLOC_FRAMES    = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  in_t  in_req,
	input  logic out_stall,
	output sts_t sts,
	output logic out_valid,
	output out_t out_res
);

	localparam int unsigned SW    = $clog2(ALLOC_FRAMES + 1);
	localparam int unsigned AW    = SW + IDX_W;
	localparam int unsigned DEPTH = (ALLOC_FRAMES + 1) * 512;
	localparam logic [51:0] RES_L = 52'(RESERVED_FRAMES);
	localparam logic [51:0] TOP_L = 52'(RESERVED_FRAMES + ALLOC_FRAMES);

	logic [63:0]   mem [DEPTH];
	logic [63:0]   rdata_q;
	logic [AW-1:0] clr_q;
	logic [SW-1:0] cnt_q;
	logic [SW-1:0] slot_q;
	logic [1:0]    level_q;
	in_t           req_q;
	logic          res_status_q;
	logic [23:0]   res_frame_q;
	logic          out_valid_q;
	out_t          out_q;

	logic [IDX_W-1:0] ix;
	logic [AW-1:0]    addr;
	logic [63:0]      wdata;
	logic             we;
	logic [51:0]      fr;
	logic [63:0]      new_frame;

	always_comb begin
		case (level_q)
			2'd0:    ix = req_q.vaddr[47:39];
			2'd1:    ix = req_q.vaddr[38:30];
			2'd2:    ix = req_q.vaddr[29:21];
			default: ix = req_q.vaddr[20:12];
		endcase
	end

	assign fr        = rdata_q[63:12];
	assign new_frame = (64'(RESERVED_FRAMES) + 64'(cnt_q)) << OFS_W;

	always_comb begin
		we    = 1'b0;
		addr  = {slot_q, ix};
		wdata = '0;
		if (cmd.clr_step) begin
			we   = 1'b1;
			addr = clr_q;
		end else if (cmd.alloc_table) begin
			we    = 1'b1;
			wdata = new_frame | 64'(PTE_PW);
		end else if (cmd.write_leaf) begin
			we    = 1'b1;
			wdata = {req_q.paddr[63:OFS_W], {OFS_W{1'b0}}} | req_q.flags;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= in_req;
		end
		if (cmd.set_result) begin
			res_status_q <= cmd.res_status;
			res_frame_q  <= cmd.res_frame ? new_frame[23:0] : 24'd0;
		end
		if (cmd.out_load) begin
			out_q.status     <= res_status_q;
			out_q.frame_addr <= res_frame_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			slot_q      <= '0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load_req) begin
				slot_q  <= '0;
				level_q <= '0;
			end
			if (cmd.take_entry) begin
				slot_q  <= SW'(fr - RES_L + 52'd1);
				level_q <= level_q + 2'd1;
			end
			if (cmd.alloc_table) begin
				slot_q  <= cnt_q + 1'b1;
				level_q <= level_q + 2'd1;
			end
			if (cmd.alloc_table || cmd.alloc_frame) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last   = (clr_q == AW'(DEPTH - 1));
	assign sts.present    = rdata_q[0];
	assign sts.in_range   = (fr >= RES_L) && (fr < TOP_L);
	assign sts.full       = (cnt_q == SW'(ALLOC_FRAMES));
	assign sts.last_level = (level_q == 2'd2);
	assign sts.req_map    = (req_q.req_type == REQ_MAP);
	assign sts.out_busy   = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// ----- sv/page_table_mapper_with_frame_allocator.sv -----
// Page table mapper with frame allocator: top level joining controller and datapath.
//
// Requests arrive on in_valid / in_stall with an in_t payload; results leave on
// out_valid / out_stall with an out_t payload, one result for every request.
// An allocate request hands out the lowest free frame, or reports that none is left.
// A map request walks four table levels, creating missing tables on the way, and
// writes the leaf entry.
// out_valid rises once an allocate request has passed S_ALLOC and S_DONE, and once
// a map request has passed S_ALLOC, S_RD and S_CHK for each upper level, S_LEAF and
// S_DONE, or sooner when the walk fails early. The table memory has a single port.
// One request is worked on at a time; the next is taken in the cycle after the result
// has moved to the output register.
// After reset the table memory is cleared one entry per cycle, all
// (ALLOC_FRAMES + 1) * 512 entries (66048 by default), during which in_stall is high.
// When the receiver stalls, the result holds in the output register; a finished
// request waits for it to drain before its own result is loaded.
module page_table_mapper_with_frame_allocator import ptm_pkg::*; #(
	parameter int unsigned RESERVED_FRAMES = 2048,
	parameter int unsigned ALLOC_FRAMES    = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	cmd_t cmd;
	sts_t sts;
	logic idle;

	assign in_stall = !idle;

	ptm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_fire(in_valid && idle),
		.sts    (sts),
		.cmd    (cmd),
		.idle   (idle)
	);

	ptm_dp #(
		.RESERVED_FRAMES(RESERVED_FRAMES),
		.ALLOC_FRAMES   (ALLOC_FRAMES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_req   (in_data),
		.out_stall(out_stall),
		.sts      (sts),
		.out_valid(out_valid),
		.out_res  (out_data)
	);

endmodule

// ----- sim/tb_page_table_mapper_with_frame_allocator.sv -----
// Self-checking testbench for the page table mapper with frame allocator.
`timescale 1ns / 1ps

module tb_page_table_mapper_with_frame_allocator;
	import ptm_pkg::*;

	localparam int unsigned RESERVED   = 2048;
	localparam int unsigned ALLOCATABLE = 128;
	localparam int unsigned ALL_FRAMES = RESERVED + ALLOCATABLE;
	localparam int unsigned ENTRIES    = 512;
	localparam int unsigned STORE_LEN  = (1 + ALLOCATABLE) * ENTRIES;
	localparam int unsigned RANDOM_REQS = 1080;
	localparam int unsigned IDLE_LIMIT = 200000;

	class frame_map_scoreboard;
		bit          frame_used[ALL_FRAMES];
		logic [63:0] tables[STORE_LEN];
		out_t        expected_q[$];
		int          errors;

		function new();
			for (int f = 0; f < ALL_FRAMES; f++)
				frame_used[f] = (f < RESERVED);
			foreach (tables[i])
				tables[i] = '0;
			errors = 0;
		endfunction

		function bit take_frame(output int unsigned f);
			for (int unsigned i = 0; i < ALL_FRAMES; i++) begin
				if (!frame_used[i]) begin
					frame_used[i] = 1'b1;
					f = i;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// Follows the entry at pos, creating its table when it is not present.
		function bit walk_level(int unsigned pos, output int unsigned slot);
			logic [63:0] entry;
			logic [63:0] fr;
			int unsigned f;
			entry = tables[pos];
			if (!entry[0]) begin
				if (!take_frame(f))
					return 1'b0;
				entry = (64'(f) << OFS_W) | 64'(PTE_PW);
				tables[pos] = entry;
			end
			fr = entry >> OFS_W;
			if (fr < RESERVED || fr >= ALL_FRAMES)
				return 1'b0;
			slot = int'(fr) - RESERVED + 1;
			return 1'b1;
		endfunction

		function void note_request(in_t req);
			out_t res;
			int unsigned f;
			int unsigned slot;
			int unsigned leaf;
			bit ok;
			res = '0;
			if (req.req_type == REQ_ALLOC) begin
				if (take_frame(f))
					res.frame_addr = 24'(f << OFS_W);
				else
					res.status = ST_FAIL;
			end else begin
				slot = 0;
				ok = walk_level(slot * ENTRIES + req.vaddr[47:39], slot);
				if (ok)
					ok = walk_level(slot * ENTRIES + req.vaddr[38:30], slot);
				if (ok)
					ok = walk_level(slot * ENTRIES + req.vaddr[29:21], slot);
				if (ok) begin
					leaf = slot * ENTRIES + req.vaddr[20:12];
					tables[leaf] = {req.paddr[63:OFS_W], {OFS_W{1'b0}}} | req.flags;
				end else begin
					res.status = ST_FAIL;
				end
			end
			expected_q.push_back(res);
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d frame_addr %h",
						got.status, got.frame_addr);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.frame_addr !== want.frame_addr) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected status %0d frame_addr %h, got %0d %h",
						want.status, want.frame_addr, got.status, got.frame_addr);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t  in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	frame_map_scoreboard sb = new();
	bit quiet = 1'b0;
	bit hold_off = 1'b0;
	int unsigned idle_cycles = 0;
	logic [26:0] prefixes[6];

	page_table_mapper_with_frame_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #2 clk = ~clk;

	// Handshakes are sampled at the falling edge, clear of any update at the rising edge.
	always @(negedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(out_data);
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 15);
			end
		end
	end

	task automatic send_request(in_t req);
		bit taken;
		while (!quiet && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do begin
			@(negedge clk);
			taken = in_valid && !in_stall;
			@(posedge clk);
		end while (!taken);
		sb.note_request(req);
	endtask

	function automatic in_t make_map(logic [47:0] va, logic [63:0] pa, logic [63:0] fl);
		in_t r;
		r.req_type = REQ_MAP;
		r.vaddr = va;
		r.paddr = pa;
		r.flags = fl;
		return r;
	endfunction

	function automatic in_t make_alloc();
		in_t r;
		r.req_type = REQ_ALLOC;
		r.vaddr = 48'({$urandom, $urandom});
		r.paddr = {$urandom, $urandom};
		r.flags = {$urandom, $urandom};
		return r;
	endfunction

	initial begin
		in_t req;
		int unsigned pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (prefixes[i])
			prefixes[i] = 27'({$urandom, $urandom});

		// Directed part: allocations, extreme addresses, repeated and shared walks.
		send_request(make_alloc());
		send_request(make_alloc());
		send_request(make_map(48'h0, 64'h0, 64'h0));
		send_request(make_map(48'h0, '1, '1));
		send_request(make_map('1, '1, '1));
		send_request(make_map('1, 64'h0, 64'h0));
		send_request(make_map(48'h0000_0000_1fff, 64'h1234_5678_9abc_def0, 64'h8000_0000_0000_0003));
		send_request(make_map(48'h0000_4000_0000, 64'hffff_ffff_ffff_f000, 64'h1));
		send_request(make_map(48'h0080_0000_0000, 64'h0000_0000_0000_0fff, 64'h0));
		send_request(make_map(48'h7fff_ffff_ffff, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa));
		send_request(make_alloc());

		for (int n = 0; n < RANDOM_REQS; n++) begin
			quiet = (n >= 400 && n < 550);
			if (n == 700)
				hold_off = 1'b1;
			pick = $urandom_range(99);
			if (pick < 8) begin
				req = make_alloc();
			end else if (pick < 18) begin
				req = make_map(48'({$urandom, $urandom}), {$urandom, $urandom},
					{$urandom, $urandom});
			end else begin
				req = make_map({prefixes[$urandom_range(5)], 9'($urandom), 12'($urandom)},
					{$urandom, $urandom}, {$urandom, $urandom});
			end
			send_request(req);
		end
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- page_table_mapper_with_frame_allocator.f -----
sv/ptm_pkg.sv
sv/ptm_ctrl.sv
sv/ptm_dp.sv
sv/page_table_mapper_with_frame_allocator.sv
sim/tb_page_table_mapper_with_frame_allocator.sv
